[hw/rtl/hkit_pkg.sv]
// shared types and constants for the key intern table
package hkit_pkg;

	localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [15:0] kind_code;
		logic [7:0]  shape_width;
		logic [7:0]  shape_rows;
		logic [31:0] length_word;
		logic [31:0] flag_word;
		logic [31:0] aux_word;
		logic [63:0] ref_handle;
	} key_t;

	typedef struct packed {
		logic [5:0] entry_index;
		logic [1:0] status;
	} result_t;

endpackage

[hw/rtl/hkit_hash.sv]
// front part: fnv-1a-64 hash of the packed key, one word per cycle, with a two entry queue
module hkit_hash (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hkit_pkg::key_t    key,
	output logic              busy,
	output logic              q_valid,
	output hkit_pkg::key_t    q_key,
	output logic [63:0]       q_hash,
	input  logic              q_pop
);

	typedef enum logic [1:0] {
		H_IDLE = 2'b01,
		H_RUN  = 2'b10
	} hstate_t;

	hstate_t        state_q;
	hkit_pkg::key_t key_q;
	logic [63:0]    hash_q;
	logic [1:0]     word_q;
	logic [63:0]    word;
	logic [63:0]    mixed;
	logic [63:0]    prod;

	// queue
	hkit_pkg::key_t qk_q [2];
	logic [63:0]    qh_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	always_comb begin
		case (word_q)
			2'd0:    word = {32'd0, key_q.kind_code, key_q.shape_width, key_q.shape_rows};
			2'd1:    word = {32'd0, key_q.length_word};
			2'd2:    word = {key_q.flag_word, key_q.aux_word};
			default: word = key_q.ref_handle;
		endcase
	end

	// prime is 2^40 + 0x1b3, so the low half of the product is a sum of shifted copies
	assign mixed = hash_q ^ word;
	assign prod  = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
		+ (mixed << 4) + (mixed << 1) + mixed;
	assign push = (state_q == H_RUN) && (word_q == 2'd3);
	assign busy = (state_q != H_IDLE) || (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			word_q  <= 2'd0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					if (start && !busy) begin
						state_q <= H_RUN;
						word_q  <= 2'd0;
					end
				end
				H_RUN: begin
					word_q <= word_q + 2'd1;
					if (word_q == 2'd3) state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q  <= key;
			hash_q <= hkit_pkg::FNV_OFFSET;
		end else if (state_q == H_RUN) begin
			hash_q <= prod;
		end
		if (push) begin
			qk_q[wp_q] <= key_q;
			qh_q[wp_q] <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_key   = qk_q[rp_q];
	assign q_hash  = qh_q[rp_q];

endmodule

[hw/rtl/hkit_probe.sv]
// back part: linear probe of the slot table and key store, find or insert, or report full
module hkit_probe #(
	parameter int ENTRIES = 64,
	parameter int SLOTS   = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  hkit_pkg::key_t    q_key,
	input  logic [63:0]       q_hash,
	output logic              q_pop,
	output logic              done,
	output hkit_pkg::result_t result
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int NW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		P_IDLE  = 4'b0001,
		P_SLOT  = 4'b0010,
		P_ENTRY = 4'b0100,
		P_CMP   = 4'b1000
	} pstate_t;

	pstate_t        state_q;
	hkit_pkg::key_t key_q;
	logic [SW-1:0]  slot_q;
	logic [NW-1:0]  n_q;
	logic [CW-1:0]  count_q;

	// slot table: valid bits and index memory
	logic [EW-1:0]  slot_mem [SLOTS];
	logic [EW-1:0]  slot_rd_q;
	logic           sval_rd_q;
	logic [SLOTS-1:0] sval_q;
	logic [EW-1:0]  idx_q;

	logic [$bits(hkit_pkg::key_t)-1:0] key_mem [ENTRIES];
	logic [$bits(hkit_pkg::key_t)-1:0] key_rd_q;

	logic [SW-1:0] hmod;
	assign hmod = SW'(q_hash % 64'(SLOTS));

	logic [SW-1:0] slot_nx;
	assign slot_nx = (32'(slot_q) == SLOTS - 1) ? '0 : slot_q + SW'(1);

	logic full;
	assign full = (32'(count_q) >= ENTRIES);

	// key read addressed by the slot read data so the stored key is ready in P_CMP
	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[slot_q];
		key_rd_q  <= key_mem[slot_rd_q];
		if (state_q == P_ENTRY && !sval_rd_q && !full) begin
			slot_mem[slot_q]           <= count_q[EW-1:0];
			key_mem[count_q[EW-1:0]]   <= key_q;
		end
		if (state_q == P_IDLE && q_valid) key_q <= q_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= P_IDLE;
			sval_q    <= '0;
			count_q   <= '0;
			done      <= 1'b0;
			result    <= '0;
			slot_q    <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			sval_rd_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				P_IDLE: begin
					if (q_valid) begin
						slot_q  <= hmod;
						n_q     <= '0;
						state_q <= P_SLOT;
					end
				end
				P_SLOT: begin
					// slot memory read issued at slot_q
					sval_rd_q <= sval_q[slot_q];
					state_q   <= P_ENTRY;
				end
				P_ENTRY: begin
					if (!sval_rd_q) begin
						done    <= 1'b1;
						state_q <= P_IDLE;
						if (full) begin
							result <= '{entry_index: 6'd0, status: hkit_pkg::ST_FULL};
						end else begin
							sval_q[slot_q] <= 1'b1;
							count_q        <= count_q + CW'(1);
							result <= '{entry_index: 6'(count_q),
								status: hkit_pkg::ST_INSERTED};
						end
					end else begin
						idx_q   <= slot_rd_q;
						state_q <= P_CMP;
					end
				end
				P_CMP: begin
					if (key_rd_q == key_q) begin
						done    <= 1'b1;
						result  <= '{entry_index: 6'(idx_q), status: hkit_pkg::ST_FOUND};
						state_q <= P_IDLE;
					end else if (32'(n_q) + 1 >= SLOTS) begin
						done    <= 1'b1;
						result  <= '{entry_index: 6'd0, status: hkit_pkg::ST_FULL};
						state_q <= P_IDLE;
					end else begin
						n_q     <= n_q + NW'(1);
						slot_q  <= slot_nx;
						state_q <= P_SLOT;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign q_pop = (state_q == P_IDLE) && q_valid;

endmodule

[hw/rtl/hashed_key_intern_table.sv]
// find-or-insert intern table: hashing front end, probing back end
// a key is hashed, queued, then probed: each slot takes P_SLOT and P_ENTRY, plus P_CMP when in use
// the front end takes no key while hashing or with a full queue; a long probe walk slows intake
// results appear for one cycle on done; the receiver cannot stall
// reset clears all slots and the entry count at once; key storage stays uninitialized
module hashed_key_intern_table #(
	parameter int ENTRIES = 64,
	parameter int SLOTS   = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hkit_pkg::key_t    key,
	output logic              busy,
	output logic              done,
	output hkit_pkg::result_t result
);

	logic           q_valid, q_pop;
	hkit_pkg::key_t q_key;
	logic [63:0]    q_hash;

	hkit_hash u_hash (
		.clk, .arst_n, .start, .key, .busy,
		.q_valid, .q_key, .q_hash, .q_pop
	);

	hkit_probe #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_probe (
		.clk, .arst_n, .q_valid, .q_key, .q_hash, .q_pop, .done, .result
	);

endmodule

[hw/rtl/hkit_checker.sv]
// port-level checks for the intern table
module hkit_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input hkit_pkg::result_t result
);

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == hkit_pkg::ST_FOUND
			|| result.status == hkit_pkg::ST_INSERTED
			|| result.status == hkit_pkg::ST_FULL)) else $error("illegal status");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == hkit_pkg::ST_FULL |-> result.entry_index == 6'd0)
		else $error("full result with nonzero index");

	a_done_pulse_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back to back results");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({busy, done})) else $error("unknown handshake");

endmodule

bind hashed_key_intern_table hkit_checker u_checker (
	.clk, .arst_n, .start, .busy, .done, .result
);
